// ----- hdl/gxwp_pkg.sv -----
`timescale 1ns / 1ps
package gxwp_pkg;

	localparam int FRAC_DIGITS_DEF = 3;
	localparam int COORD_WIDTH_DEF = 32;

	// Character codes the scanner reacts to
	localparam logic [7:0] CH_G     = 8'h67;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_Y     = 8'h79;
	localparam logic [7:0] CH_Z     = 8'h7A;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	// Per-item control handed from the scanner to the commit pipeline
	typedef struct packed {
		logic  commit;
		logic  emit;
		logic  neg;
		axis_t axis;
	} gxwp_ctrl_t;

	function automatic longint unsigned pow10(input int k);
		longint unsigned r;
		r = 1;
		for (int i = 0; i < k; i++) begin
			r = r * 10;
		end
		return r;
	endfunction

endpackage

// ----- hdl/gxwp_scan.sv -----
`timescale 1ns / 1ps
module gxwp_scan #(
	parameter int FRAC_DIGITS = gxwp_pkg::FRAC_DIGITS_DEF,
	parameter int COORD_WIDTH = gxwp_pkg::COORD_WIDTH_DEF,
	parameter int FDW         = (FRAC_DIGITS > 0) ? $clog2(FRAC_DIGITS + 1) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  logic [7:0]               char_code,
	input  logic                     end_of_file,
	output gxwp_pkg::gxwp_ctrl_t     ctrl,
	output logic [COORD_WIDTH-2:0]   mag,
	output logic [FDW-1:0]           fd
);
	import gxwp_pkg::*;

	localparam int MW = COORD_WIDTH - 1;
	localparam int AW = COORD_WIDTH + 3;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'b001,
		MODE_CODE = 3'b010,
		MODE_NUM  = 3'b100
	} mode_t;

	mode_t          mode_q, mode_d;
	axis_t          axis_q, axis_d;
	logic [MW-1:0]  mag_q, mag_d;
	logic [FDW-1:0] fd_q, fd_d;
	logic           neg_q, neg_d;
	logic           point_q, point_d;
	logic           closed_q, closed_d;
	logic           pend_q, pend_d;
	logic           line_q, line_d;

	logic           digit, numch;
	logic [AW-1:0]  acc;
	logic [MW-1:0]  acc_sat;

	localparam logic [AW-1:0] MAG_MAX = {4'b0, {MW{1'b1}}};

	assign digit = !end_of_file && (char_code >= CH_0) && (char_code <= CH_9);
	assign numch = digit || (!end_of_file && (char_code == CH_DOT || char_code == CH_MINUS));

	// mag*10 + digit, clamped to the largest magnitude
	assign acc = {3'b0, mag_q, 1'b0} + {1'b0, mag_q, 3'b0} + AW'(char_code[3:0]);
	assign acc_sat = (acc > MAG_MAX) ? {MW{1'b1}} : acc[MW-1:0];

	always_comb begin
		logic first;
		first    = !pend_q;
		mode_d   = mode_q;
		axis_d   = axis_q;
		mag_d    = mag_q;
		fd_d     = fd_q;
		neg_d    = neg_q;
		point_d  = point_q;
		closed_d = closed_q;
		pend_d   = pend_q;
		line_d   = line_q;
		ctrl.commit = 1'b0;
		ctrl.emit   = 1'b0;
		ctrl.neg    = neg_q;
		ctrl.axis   = axis_q;

		case (mode_q)
			MODE_CODE: begin
				if (digit) begin
					pend_d = 1'b1;
				end else begin
					mode_d = MODE_IDLE;
				end
			end
			MODE_NUM: begin
				if (numch) begin
					pend_d = 1'b1;
					if (!closed_q) begin
						if (char_code == CH_MINUS) begin
							if (first) begin
								neg_d = 1'b1;
							end else begin
								closed_d = 1'b1;
							end
						end else if (char_code == CH_DOT) begin
							if (point_q) begin
								closed_d = 1'b1;
							end else begin
								point_d = 1'b1;
							end
						end else if (!point_q) begin
							mag_d = acc_sat;
						end else if (fd_q < FDW'(FRAC_DIGITS)) begin
							mag_d = acc_sat;
							fd_d  = fd_q + FDW'(1);
						end
					end
				end else begin
					ctrl.commit = 1'b1;
					mode_d      = MODE_IDLE;
				end
			end
			default: begin
			end
		endcase

		if (end_of_file) begin
			if (pend_d) begin
				pend_d    = 1'b0;
				ctrl.emit = 1'b1;
			end
		end else if (char_code == CH_G) begin
			mode_d = MODE_CODE;
			pend_d = 1'b0;
			line_d = 1'b0;
		end else if (char_code == CH_X || char_code == CH_Y || char_code == CH_Z) begin
			mode_d   = MODE_NUM;
			axis_d   = (char_code == CH_X) ? AXIS_X : (char_code == CH_Y) ? AXIS_Y : AXIS_Z;
			mag_d    = '0;
			fd_d     = '0;
			neg_d    = 1'b0;
			point_d  = 1'b0;
			closed_d = 1'b0;
			pend_d   = 1'b0;
			line_d   = 1'b0;
		end else if (char_code == CH_NL && !line_q) begin
			pend_d    = 1'b0;
			line_d    = 1'b1;
			ctrl.emit = 1'b1;
		end
	end

	assign mag = mag_q;
	assign fd  = fd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			axis_q   <= AXIS_X;
			mag_q    <= '0;
			fd_q     <= '0;
			neg_q    <= 1'b0;
			point_q  <= 1'b0;
			closed_q <= 1'b0;
			pend_q   <= 1'b0;
			line_q   <= 1'b1;
		end else if (go) begin
			mode_q   <= mode_d;
			axis_q   <= axis_d;
			mag_q    <= mag_d;
			fd_q     <= fd_d;
			neg_q    <= neg_d;
			point_q  <= point_d;
			closed_q <= closed_d;
			pend_q   <= pend_d;
			line_q   <= line_d;
		end
	end

endmodule

// ----- hdl/gcode_xyz_word_parser_core.sv -----
`timescale 1ns / 1ps
// A result passes stages 1, 2 and 3 and the output register before m_tdata.
// Throughput: one text byte per cycle unless the output stalls; the scanner state is a loop.
// The output register lets the next byte in while a point waits for m_tready.
// Reset (arst_n low, asynchronous): pipeline empty, scanner idle, x/y/z all zero,
// no word pending; no clearing pass is needed.
module gcode_xyz_word_parser_core #(
	parameter int FRAC_DIGITS = gxwp_pkg::FRAC_DIGITS_DEF,
	parameter int COORD_WIDTH = gxwp_pkg::COORD_WIDTH_DEF,
	parameter int TDW         = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [7:0]     s_tdata,   // char_code[7:0]
	input  logic           s_tlast,   // end_of_file
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [TDW-1:0] m_tdata    // pos_x, pos_y, pos_z (COORD_WIDTH each), zero pad
);
	import gxwp_pkg::*;

	localparam int CW   = COORD_WIDTH;
	localparam int MW   = CW - 1;
	localparam int FDW  = (FRAC_DIGITS > 0) ? $clog2(FRAC_DIGITS + 1) : 1;
	localparam int P10W = $clog2(pow10(FRAC_DIGITS) + 1);
	localparam int PW   = MW + P10W;

	// Stage 1: registered input byte
	logic        v_s1;
	logic [7:0]  char_s1;
	logic        eof_s1;

	// Stage 2: scanner output (commit request and emit flag)
	logic           v_s2;
	gxwp_ctrl_t     ctrl_s2;
	logic [MW-1:0]  mag_s2;
	logic [FDW-1:0] fd_s2;

	// Stage 3: scaled magnitude
	logic           v_s3;
	gxwp_ctrl_t     ctrl_s3;
	logic [PW-1:0]  prod_s3;

	// Axis registers and output register
	logic [CW-1:0]  axis_q [3];
	logic [CW-1:0]  axis_d [3];
	logic           out_vld_q;
	logic [TDW-1:0] out_data_q;

	gxwp_ctrl_t     scan_ctrl;
	logic [MW-1:0]  scan_mag;
	logic [FDW-1:0] scan_fd;

	logic go1, go2, go3, ld2, ld3, out_free;

	// Stall chain: each stage moves when the next one has room.
	// Only an emitting item needs the output register.
	assign out_free = !out_vld_q || m_tready;
	assign go3      = v_s3 && (!ctrl_s3.emit || out_free);
	assign ld3      = !v_s3 || go3;
	assign go2      = v_s2 && ld3;
	assign ld2      = !v_s2 || go2;
	assign go1      = v_s1 && ld2;
	assign s_tready = !v_s1 || go1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (s_tready) begin
				v_s1 <= s_tvalid;
			end
			if (ld2) begin
				v_s2 <= v_s1;
			end
			if (ld3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			eof_s1  <= s_tlast;
		end
	end

	// Scanner: character classification and word state, one byte per cycle while go1 is high
	gxwp_scan #(
		.FRAC_DIGITS(FRAC_DIGITS),
		.COORD_WIDTH(COORD_WIDTH),
		.FDW        (FDW)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (go1),
		.char_code  (char_s1),
		.end_of_file(eof_s1),
		.ctrl       (scan_ctrl),
		.mag        (scan_mag),
		.fd         (scan_fd)
	);

	always_ff @(posedge clk) begin
		if (go1) begin
			ctrl_s2 <= scan_ctrl;
			mag_s2  <= scan_mag;
			fd_s2   <= scan_fd;
		end
	end

	// Scale by 10^(FRAC_DIGITS - fraction digits taken) for missing fraction digits
	logic [P10W-1:0] scale;

	always_comb begin
		scale = '0;
		for (int i = 0; i <= FRAC_DIGITS; i++) begin
			if (fd_s2 == FDW'(i)) begin
				scale = P10W'(pow10(FRAC_DIGITS - i));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go2) begin
			ctrl_s3 <= ctrl_s2;
			prod_s3 <= PW'(mag_s2) * PW'(scale);
		end
	end

	// Stage 3: clamp, apply sign, write the axis; emit sees the fresh value
	localparam logic [PW-1:0] PROD_MAX = {{P10W{1'b0}}, {MW{1'b1}}};

	logic [MW-1:0] mag_sat;
	logic [CW-1:0] coord;

	assign mag_sat = (prod_s3 > PROD_MAX) ? {MW{1'b1}} : prod_s3[MW-1:0];
	assign coord   = ctrl_s3.neg ? (CW'(0) - {1'b0, mag_sat}) : {1'b0, mag_sat};

	always_comb begin
		axis_d = axis_q;
		if (v_s3 && ctrl_s3.commit) begin
			case (ctrl_s3.axis)
				AXIS_X:  axis_d[0] = coord;
				AXIS_Y:  axis_d[1] = coord;
				AXIS_Z:  axis_d[2] = coord;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				axis_q[i] <= '0;
			end
			out_vld_q <= 1'b0;
		end else begin
			if (go3) begin
				axis_q <= axis_d;
			end
			if (out_free) begin
				out_vld_q <= go3 && ctrl_s3.emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go3 && ctrl_s3.emit) begin
			out_data_q <= TDW'({axis_d[2], axis_d[1], axis_d[0]});
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
	import gxwp_pkg::*;

	localparam int FRAC = FRAC_DIGITS_DEF;
	localparam int CW   = COORD_WIDTH_DEF;
	localparam int TDW  = ((3 * CW + 7) / 8) * 8;
	localparam longint unsigned CMAX = (64'd1 << (CW - 1)) - 1;
	localparam int HOLD_CYCLES = 300;

	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;

	typedef enum logic [1:0] {
		SCAN_IDLE = 2'd0,
		SCAN_CODE = 2'd1,
		SCAN_NUM  = 2'd2
	} scan_t;

	// One request: a text byte or the end-of-file mark
	typedef struct packed {
		logic [7:0] ch;
		logic       eof;
	} text_t;

	logic           clk;
	logic           arst_n;
	logic           s_tvalid;
	logic           s_tready;
	logic [7:0]     s_tdata;
	logic           s_tlast;
	logic           m_tvalid;
	logic           m_tready;
	logic [TDW-1:0] m_tdata;

	gcode_xyz_word_parser_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	text_t                 text_q[$];
	logic [3*CW-1:0]       point_q[$];

	// Shadow of the scanner state
	scan_t                 scan;
	axis_t                 cur_axis;
	longint unsigned       mag;
	logic                  neg;
	logic                  dot_seen;
	int                    frac_cnt;
	logic                  closed;
	logic                  pending;
	logic                  line_clear;
	logic [CW-1:0]         coord[3];

	int send_idle;
	int recv_idle;
	logic long_hold;
	int hold_cnt = 0;
	logic req_taken;
	int errors;
	int n_req;
	int n_eof;
	int n_points;
	int n_sat;

	function automatic longint unsigned sat_mac10(input longint unsigned a,
			input int unsigned add);
		if (a > (CMAX - add) / 10)
			return CMAX;
		return a * 10 + add;
	endfunction

	// Fold the accumulated digits into thousandths and store on the axis
	task automatic commit_coord();
		longint unsigned m;
		m = mag;
		for (int k = frac_cnt; k < FRAC; k++)
			m = sat_mac10(m, 0);
		if (m == CMAX)
			n_sat++;
		if (neg)
			m = -m;
		if (cur_axis != 2'd3)
			coord[cur_axis] = m[CW-1:0];
	endtask

	task automatic number_char(input logic [7:0] c);
		logic first;
		first = !pending;
		pending = 1'b1;
		if (closed)
			return;
		if (c == CH_MINUS) begin
			if (first)
				neg = 1'b1;
			else
				closed = 1'b1;
		end else if (c == CH_DOT) begin
			if (dot_seen)
				closed = 1'b1;
			else
				dot_seen = 1'b1;
		end else if (!dot_seen) begin
			mag = sat_mac10(mag, c - CH_0);
		end else if (frac_cnt < FRAC) begin
			mag = sat_mac10(mag, c - CH_0);
			frac_cnt++;
		end
	endtask

	task automatic start_word(input axis_t a);
		scan = SCAN_NUM;
		cur_axis = a;
		mag = 0;
		neg = 1'b0;
		dot_seen = 1'b0;
		frac_cnt = 0;
		closed = 1'b0;
		pending = 1'b0;
		line_clear = 1'b0;
	endtask

	// Advance the shadow scanner by one request, queue the point it emits
	task automatic scan_char(input logic [7:0] c, input logic eof);
		logic digit;
		logic numch;
		digit = !eof && c >= CH_0 && c <= CH_9;
		numch = digit || (!eof && (c == CH_DOT || c == CH_MINUS));
		if (scan == SCAN_CODE) begin
			if (digit)
				pending = 1'b1;
			else
				scan = SCAN_IDLE;
		end else if (scan == SCAN_NUM) begin
			if (numch) begin
				number_char(c);
			end else begin
				commit_coord();
				scan = SCAN_IDLE;
			end
		end
		if (eof) begin
			if (pending) begin
				pending = 1'b0;
				point_q.push_back({coord[2], coord[1], coord[0]});
			end
			return;
		end
		if (c == CH_G) begin
			scan = SCAN_CODE;
			pending = 1'b0;
			line_clear = 1'b0;
		end else if (c == CH_X) begin
			start_word(AXIS_X);
		end else if (c == CH_Y) begin
			start_word(AXIS_Y);
		end else if (c == CH_Z) begin
			start_word(AXIS_Z);
		end else if (c == CH_NL && !line_clear) begin
			pending = 1'b0;
			line_clear = 1'b1;
			point_q.push_back({coord[2], coord[1], coord[0]});
		end
	endtask

	task automatic add_char(input logic [7:0] c);
		text_q.push_back({c, 1'b0});
	endtask

	task automatic add_eof();
		text_q.push_back({8'($urandom_range(0, 255)), 1'b1});
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			add_char(s[i]);
	endtask

	task automatic add_digits(input int n);
		for (int i = 0; i < n; i++)
			add_char(CH_0 + 8'($urandom_range(0, 9)));
	endtask

	// Number body: optional sign, integer part (now and then long enough to
	// saturate), optional fraction, sometimes broken by a stray sign or point
	task automatic add_number();
		if ($urandom_range(0, 2) == 0)
			add_char(CH_MINUS);
		if ($urandom_range(0, 14) == 0)
			add_digits($urandom_range(10, 14));
		else
			add_digits($urandom_range(0, 4));
		if ($urandom_range(0, 2) != 0) begin
			add_char(CH_DOT);
			add_digits($urandom_range(0, 5));
		end
		if ($urandom_range(0, 9) == 0) begin
			add_char($urandom_range(0, 1) ? CH_MINUS : CH_DOT);
			add_digits($urandom_range(0, 2));
		end
	endtask

	task automatic add_line();
		int nwords;
		int r;
		nwords = $urandom_range(0, 4);
		for (int w = 0; w < nwords; w++) begin
			case ($urandom_range(0, 3))
				0: begin
					add_char(CH_G);
					add_digits($urandom_range(0, 3));
				end
				1: begin
					add_char(CH_X);
					add_number();
				end
				2: begin
					add_char(CH_Y);
					add_number();
				end
				default: begin
					add_char(CH_Z);
					add_number();
				end
			endcase
			r = $urandom_range(0, 9);
			if (r <= 5)
				add_char(CH_SP);
			else if (r == 8)
				add_char(8'($urandom_range(0, 255)));
			else if (r == 9)
				add_char(CH_TAB);
		end
		r = $urandom_range(0, 19);
		if (r < 16) begin
			add_char(CH_NL);
		end else if (r == 16) begin
			add_eof();
		end else if (r == 17) begin
			add_char(8'($urandom_range(0, 255)));
		end else if (r == 18) begin
			add_char(CH_NL);
			add_char(CH_NL);
		end
	endtask

	// Mostly well-formed lines, about one in ten a burst of raw bytes
	task automatic add_random(input int n);
		int target;
		target = text_q.size() + n;
		while (text_q.size() < target) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 6)) begin
					if ($urandom_range(0, 7) == 0)
						add_eof();
					else
						add_char(8'($urandom_range(0, 255)));
				end
			end else begin
				add_line();
			end
		end
	endtask

	task automatic drain_input();
		while (text_q.size() != 0)
			@(posedge clk);
	endtask

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Sender: holds a request until taken, otherwise offers the next one
	always @(negedge clk) begin
		if (!(s_tvalid && !req_taken)) begin
			req_taken = 1'b0;
			if (arst_n && text_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
				s_tvalid <= 1'b1;
				s_tdata  <= text_q[0].ch;
				s_tlast  <= text_q[0].eof;
			end else begin
				s_tvalid <= 1'b0;
				s_tdata  <= 8'($urandom);
				s_tlast  <= 1'($urandom);
			end
		end
	end

	// Receiver: once a long hold is requested it keeps m_tready low until hold_cnt reaches HOLD_CYCLES
	always @(negedge clk) begin
		if (long_hold && hold_cnt < HOLD_CYCLES) begin
			hold_cnt++;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	// Monitor: checks the point leaving, then predicts from the request taken
	always @(posedge clk) begin
		logic [3*CW-1:0] want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (point_q.size() == 0) begin
					errors++;
					$display("%0t: expected no point, got x=%0d y=%0d z=%0d", $time,
						$signed(m_tdata[CW-1:0]), $signed(m_tdata[2*CW-1:CW]),
						$signed(m_tdata[3*CW-1:2*CW]));
				end else begin
					want = point_q.pop_front();
					n_points++;
					for (int f = 0; f < 3; f++) begin
						if (m_tdata[f*CW +: CW] !== want[f*CW +: CW]) begin
							errors++;
							$display("%0t: pos_%s expected %0d, got %0d", $time,
								f == 0 ? "x" : (f == 1 ? "y" : "z"),
								$signed(want[f*CW +: CW]),
								$signed(m_tdata[f*CW +: CW]));
						end
					end
				end
			end
			if (s_tvalid && s_tready) begin
				scan_char(s_tdata, s_tlast);
				void'(text_q.pop_front());
				req_taken = 1'b1;
				n_req++;
				if (s_tlast)
					n_eof++;
			end
		end
	end

	initial begin
		#1_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		m_tready  = 1'b0;
		req_taken = 1'b0;
		long_hold = 1'b0;
		send_idle = 30;
		recv_idle = 49;
		errors    = 0;
		n_req     = 0;
		n_eof     = 0;
		n_points  = 0;
		n_sat     = 0;

		scan       = SCAN_IDLE;
		cur_axis   = AXIS_X;
		mag        = 0;
		neg        = 1'b0;
		dot_seen   = 1'b0;
		frac_cnt   = 0;
		closed     = 1'b0;
		pending    = 1'b0;
		line_clear = 1'b1;
		for (int a = 0; a < 3; a++)
			coord[a] = '0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: negative with truncated fraction, lone minus, lone point,
		// newline with nothing new on the line, code word digits, end of file,
		// second point and late minus, and end of file repeated
		add_str("x-1.2345");
		add_str("y-");
		add_str("z.");
		add_char(CH_NL);
		add_char(CH_NL);
		add_str("g12");
		add_eof();
		add_str("x1.2.3-");
		add_eof();
		add_eof();
		drain_input();

		add_random(310);
		drain_input();

		send_idle = 49;
		recv_idle = 30;
		add_random(310);
		drain_input();

		// No idling; the receiver stalls long enough to back up the input
		send_idle = 0;
		recv_idle = 0;
		add_random(310);
		repeat (40) @(posedge clk);
		long_hold = 1'b1;
		drain_input();

		while (point_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("tb: %0d requests (%0d end-of-file), %0d points checked, %0d saturated",
			n_req, n_eof, n_points, n_sat);
		$display("tb: idle mixes 30/49, 49/30, none, plus a 300-cycle output stall");
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
